// ===== hdl/acc_pkg.sv =====
// ----------------------------------------------------------------------------
// acc_pkg
// Shared types, op codes and small arithmetic helpers for the alarm clock
// controller.
// ----------------------------------------------------------------------------
package acc_pkg;

    // op codes of an input item
    localparam logic [3:0] OP_TICK    = 4'd0;
    localparam logic [3:0] OP_SNOOZE  = 4'd1;
    localparam logic [3:0] OP_STOP    = 4'd2;
    localparam logic [3:0] OP_TOGGLE  = 4'd3;
    localparam logic [3:0] OP_EDIT    = 4'd4;
    localparam logic [3:0] OP_UP      = 4'd5;
    localparam logic [3:0] OP_DOWN    = 4'd6;
    localparam logic [3:0] OP_RIGHT   = 4'd7;
    localparam logic [3:0] OP_LEFT    = 4'd8;
    localparam logic [3:0] OP_CONFIRM = 4'd9;
    localparam logic [3:0] OP_CANCEL  = 4'd10;

    localparam logic [5:0] SNOOZE_RESET = 6'd5;

    // cursor positions
    localparam logic [1:0] CUR_HOUR_TENS   = 2'd0;
    localparam logic [1:0] CUR_HOUR_ONES   = 2'd1;
    localparam logic [1:0] CUR_MINUTE_TENS = 2'd2;
    localparam logic [1:0] CUR_MINUTE_ONES = 2'd3;

    typedef struct packed {
        logic [3:0] op;
        logic [4:0] now_hours;
        logic [5:0] now_minutes;
    } t_in_item;

    typedef struct packed {
        logic       buzzer_on;
        logic       alarm_enabled;
        logic       edit_active;
        logic [1:0] digit_hour_tens;
        logic [3:0] digit_hour_ones;
        logic [2:0] digit_minute_tens;
        logic [3:0] digit_minute_ones;
        logic [1:0] cursor_position;
        logic [4:0] set_hours;
        logic [5:0] set_minutes;
    } t_out_item;

    typedef struct packed {
        logic [1:0] hour_tens;
        logic [3:0] hour_ones;
        logic [2:0] minute_tens;
        logic [3:0] minute_ones;
    } t_digits;

    typedef struct packed {
        logic       up;
        logic       down;
        logic [1:0] cursor;
    } t_edit_cmd;

    function automatic logic [1:0] hour_tens(input logic [4:0] h);
        logic [1:0] t;
        if (h >= 5'd30)      t = 2'd3;
        else if (h >= 5'd20) t = 2'd2;
        else if (h >= 5'd10) t = 2'd1;
        else                 t = 2'd0;
        return t;
    endfunction

    function automatic logic [2:0] minute_tens(input logic [5:0] m);
        logic [2:0] t;
        if (m >= 6'd60)      t = 3'd6;
        else if (m >= 6'd50) t = 3'd5;
        else if (m >= 6'd40) t = 3'd4;
        else if (m >= 6'd30) t = 3'd3;
        else if (m >= 6'd20) t = 3'd2;
        else if (m >= 6'd10) t = 3'd1;
        else                 t = 3'd0;
        return t;
    endfunction

    // ten times a digit, as shift and add
    function automatic logic [6:0] times_ten(input logic [2:0] d);
        return {1'b0, d, 3'b000} + {3'b000, d, 1'b0};
    endfunction

endpackage

// ===== hdl/acc_digit_edit.sv =====
// ----------------------------------------------------------------------------
// acc_digit_edit
// Up and down stepping of the selected HH:MM digit with constrained wrap.
// ----------------------------------------------------------------------------
module acc_digit_edit (
    input  acc_pkg::t_digits   i_digits,
    input  acc_pkg::t_edit_cmd i_cmd,
    output acc_pkg::t_digits   o_digits
);

    logic [2:0] w_ht_inc;
    logic [4:0] w_ho_inc;
    logic [3:0] w_mt_inc;
    logic [4:0] w_mo_inc;

    assign w_ht_inc = {1'b0, i_digits.hour_tens} + 3'd1;
    assign w_ho_inc = {1'b0, i_digits.hour_ones} + 5'd1;
    assign w_mt_inc = {1'b0, i_digits.minute_tens} + 4'd1;
    assign w_mo_inc = {1'b0, i_digits.minute_ones} + 5'd1;

    always_comb begin
        o_digits = i_digits;
        if (i_cmd.up) begin
            unique case (i_cmd.cursor)
                acc_pkg::CUR_HOUR_TENS: begin
                    if (w_ht_inc >= 3'd3) begin
                        o_digits.hour_tens = 2'd0;
                    end else begin
                        o_digits.hour_tens = w_ht_inc[1:0];
                        // hours above 23 not allowed
                        if (w_ht_inc == 3'd2 && i_digits.hour_ones >= 4'd4) begin
                            o_digits.hour_ones = 4'd3;
                        end
                    end
                end
                acc_pkg::CUR_HOUR_ONES: begin
                    if (i_digits.hour_tens < 2'd2) begin
                        o_digits.hour_ones = (w_ho_inc >= 5'd10) ? 4'd0 : w_ho_inc[3:0];
                    end else begin
                        o_digits.hour_ones = (w_ho_inc >= 5'd4) ? 4'd0 : w_ho_inc[3:0];
                    end
                end
                acc_pkg::CUR_MINUTE_TENS: begin
                    o_digits.minute_tens = (w_mt_inc >= 4'd6) ? 3'd0 : w_mt_inc[2:0];
                end
                acc_pkg::CUR_MINUTE_ONES: begin
                    o_digits.minute_ones = (w_mo_inc >= 5'd10) ? 4'd0 : w_mo_inc[3:0];
                end
                default: begin
                    o_digits = i_digits;
                end
            endcase
        end else if (i_cmd.down) begin
            unique case (i_cmd.cursor)
                acc_pkg::CUR_HOUR_TENS: begin
                    if (i_digits.hour_tens == 2'd0) begin
                        o_digits.hour_tens = 2'd2;
                        if (i_digits.hour_ones >= 4'd4) begin
                            o_digits.hour_ones = 4'd3;
                        end
                    end else begin
                        o_digits.hour_tens = i_digits.hour_tens - 2'd1;
                    end
                end
                acc_pkg::CUR_HOUR_ONES: begin
                    if (i_digits.hour_ones == 4'd0) begin
                        o_digits.hour_ones = (i_digits.hour_tens < 2'd2) ? 4'd9 : 4'd3;
                    end else begin
                        o_digits.hour_ones = i_digits.hour_ones - 4'd1;
                    end
                end
                acc_pkg::CUR_MINUTE_TENS: begin
                    o_digits.minute_tens = (i_digits.minute_tens == 3'd0) ?
                                           3'd5 : i_digits.minute_tens - 3'd1;
                end
                acc_pkg::CUR_MINUTE_ONES: begin
                    o_digits.minute_ones = (i_digits.minute_ones == 4'd0) ?
                                           4'd9 : i_digits.minute_ones - 4'd1;
                end
                default: begin
                    o_digits = i_digits;
                end
            endcase
        end
    end

endmodule

// ===== hdl/acc_state.sv =====
// ----------------------------------------------------------------------------
// acc_state
// Alarm state registers and their update for one item; presents the state
// as it stands after the item.
// ----------------------------------------------------------------------------
module acc_state (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [5:0]        i_cfg_wr_data,
    input  logic              i_step,
    input  acc_pkg::t_in_item i_item,
    output acc_pkg::t_out_item o_next
);

    logic [5:0]       r_snooze;
    logic [4:0]       r_hour;
    logic [5:0]       r_minute;
    logic             r_enabled;
    logic             r_ringing;
    logic             r_editing;
    acc_pkg::t_digits r_digits;
    logic [1:0]       r_cursor;

    logic [4:0]       n_hour;
    logic [5:0]       n_minute;
    logic             n_enabled;
    logic             n_ringing;
    logic             n_editing;
    acc_pkg::t_digits n_digits;
    logic [1:0]       n_cursor;

    acc_pkg::t_edit_cmd w_cmd;
    acc_pkg::t_digits   w_edited;
    acc_pkg::t_digits   w_split;

    logic [6:0] w_sum;
    logic [1:0] w_carry;
    logic [6:0] w_min_wrap;
    logic [5:0] w_hour_sum;
    logic [5:0] w_hour_wrap;
    logic [6:0] w_conf_hour;
    logic [6:0] w_conf_min;

    assign w_cmd.up     = r_editing && (i_item.op == acc_pkg::OP_UP);
    assign w_cmd.down   = r_editing && (i_item.op == acc_pkg::OP_DOWN);
    assign w_cmd.cursor = r_cursor;

    acc_digit_edit u_digit_edit (
        .i_digits (r_digits),
        .i_cmd    (w_cmd),
        .o_digits (w_edited)
    );

    // snooze: minutes wrap by 60 with carry into the hours
    assign w_sum = {1'b0, r_minute} + {1'b0, r_snooze};

    always_comb begin
        priority if (w_sum >= 7'd120) begin
            w_carry    = 2'd2;
            w_min_wrap = w_sum - 7'd120;
        end else if (w_sum >= 7'd60) begin
            w_carry    = 2'd1;
            w_min_wrap = w_sum - 7'd60;
        end else begin
            w_carry    = 2'd0;
            w_min_wrap = w_sum;
        end
    end

    assign w_hour_sum  = {1'b0, r_hour} + {4'd0, w_carry};
    assign w_hour_wrap = (w_hour_sum >= 6'd24) ? w_hour_sum - 6'd24 : w_hour_sum;

    // alarm time split into digits on entry to edit mode
    always_comb begin
        logic [6:0] ten_h;
        logic [6:0] ten_m;
        w_split.hour_tens   = acc_pkg::hour_tens(r_hour);
        w_split.minute_tens = acc_pkg::minute_tens(r_minute);
        ten_h = acc_pkg::times_ten({1'b0, w_split.hour_tens});
        ten_m = acc_pkg::times_ten(w_split.minute_tens);
        w_split.hour_ones   = 4'({2'b00, r_hour} - ten_h);
        w_split.minute_ones = 4'({1'b0, r_minute} - ten_m);
    end

    assign w_conf_hour = acc_pkg::times_ten({1'b0, r_digits.hour_tens})
                         + {3'd0, r_digits.hour_ones};
    assign w_conf_min  = acc_pkg::times_ten(r_digits.minute_tens)
                         + {3'd0, r_digits.minute_ones};

    always_comb begin
        n_hour    = r_hour;
        n_minute  = r_minute;
        n_enabled = r_enabled;
        n_ringing = r_ringing;
        n_editing = r_editing;
        n_digits  = r_digits;
        n_cursor  = r_cursor;
        unique case (i_item.op)
            acc_pkg::OP_TICK: begin
                if (r_enabled && i_item.now_hours == r_hour
                        && i_item.now_minutes == r_minute) begin
                    n_ringing = 1'b1;
                end
            end
            acc_pkg::OP_SNOOZE: begin
                if (r_ringing) begin
                    n_ringing = 1'b0;
                    n_minute  = w_min_wrap[5:0];
                    n_hour    = w_hour_wrap[4:0];
                end
            end
            acc_pkg::OP_STOP: begin
                if (r_ringing) begin
                    n_ringing = 1'b0;
                    n_enabled = 1'b0;
                end
            end
            acc_pkg::OP_TOGGLE: begin
                n_enabled = ~r_enabled;
                if (r_enabled) begin
                    n_ringing = 1'b0;
                end
            end
            acc_pkg::OP_EDIT: begin
                if (!r_editing) begin
                    n_editing = 1'b1;
                    n_digits  = w_split;
                    n_cursor  = acc_pkg::CUR_HOUR_TENS;
                end
            end
            acc_pkg::OP_UP, acc_pkg::OP_DOWN: begin
                n_digits = w_edited;
            end
            acc_pkg::OP_RIGHT: begin
                if (r_editing) begin
                    n_cursor = r_cursor + 2'd1;
                end
            end
            acc_pkg::OP_LEFT: begin
                if (r_editing) begin
                    n_cursor = r_cursor - 2'd1;
                end
            end
            acc_pkg::OP_CONFIRM: begin
                if (r_editing) begin
                    n_hour    = w_conf_hour[4:0];
                    n_minute  = w_conf_min[5:0];
                    n_enabled = 1'b1;
                    n_editing = 1'b0;
                end
            end
            acc_pkg::OP_CANCEL: begin
                n_editing = 1'b0;
            end
            default: begin
                n_editing = r_editing;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snooze  <= acc_pkg::SNOOZE_RESET;
            r_hour    <= '0;
            r_minute  <= '0;
            r_enabled <= 1'b0;
            r_ringing <= 1'b0;
            r_editing <= 1'b0;
            r_digits  <= '0;
            r_cursor  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_snooze <= i_cfg_wr_data;
            end
            if (i_step) begin
                r_hour    <= n_hour;
                r_minute  <= n_minute;
                r_enabled <= n_enabled;
                r_ringing <= n_ringing;
                r_editing <= n_editing;
                r_digits  <= n_digits;
                r_cursor  <= n_cursor;
            end
        end
    end

    assign o_next.buzzer_on         = n_ringing;
    assign o_next.alarm_enabled     = n_enabled;
    assign o_next.edit_active       = n_editing;
    assign o_next.digit_hour_tens   = n_digits.hour_tens;
    assign o_next.digit_hour_ones   = n_digits.hour_ones;
    assign o_next.digit_minute_tens = n_digits.minute_tens;
    assign o_next.digit_minute_ones = n_digits.minute_ones;
    assign o_next.cursor_position   = n_cursor;
    assign o_next.set_hours         = n_hour;
    assign o_next.set_minutes       = n_minute;

endmodule

// ===== hdl/alarm_clock_controller.sv =====
// ----------------------------------------------------------------------------
// alarm_clock_controller
// Alarm clock controller: minute ticks and button events in, one status
// result per item out.
// ----------------------------------------------------------------------------
//  channel   signals                               direction
//  input     i_in_valid / o_in_ready / i_in_item   item in
//  output    o_out_valid / i_out_ready / o_out_item result out
//  config    i_cfg_wr_en / i_cfg_wr_data           snooze minutes
//
//  one item per cycle sustained while the output is ready; a result is presented
//  after its transfer in passes the input register, then the state update into the result register
//  synchronous active-low reset; snooze minutes reset to 5, state and valid flags to zero
//  a stalled output holds its result while the input register keeps taking
//  one further item; ready falls only when both registers are full
// ----------------------------------------------------------------------------
module alarm_clock_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  acc_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output acc_pkg::t_out_item o_out_item,
    input  logic               i_cfg_wr_en,
    input  logic [5:0]         i_cfg_wr_data
);

    logic               r_in_valid;
    acc_pkg::t_in_item  r_in_item;
    logic               r_out_valid;
    acc_pkg::t_out_item r_out_item;

    logic               w_step;
    acc_pkg::t_out_item w_next;

    // item moves on when the result register is free or being emptied
    assign w_step     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_step;

    acc_state u_state (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (w_step),
        .i_item        (r_in_item),
        .o_next        (w_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
        if (w_step) begin
            r_out_item <= w_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
